### rtl/tvg_pkg.sv
// Torus vertex generator package: word types, register codes, pipeline depths.
// No dependencies; used by every file of the block but tvg_delay.
package tvg_pkg;

  localparam int STEP_W     = 10;
  localparam int SEG_W      = 10;
  localparam int RAD_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TEX_FRAC   = 16;
  localparam int IDX_W      = 20;
  localparam int MAX_SEGMENTS = 1024;
  localparam int ANGLE_BITS   = 16;
  localparam int DIV_BPS    = 4;
  localparam int SINE_LAT   = 7;
  localparam int GEOM_LAT   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAJOR_RADIUS   = 3'd0,
    CFG_MINOR_RADIUS   = 3'd1,
    CFG_MAJOR_SEGMENTS = 3'd2,
    CFG_MINOR_SEGMENTS = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [STEP_W-1:0] major_step;
    logic [STEP_W-1:0] minor_step;
  } vtx_in_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [IDX_W-1:0]   vertex_index;
  } vtx_out_t;

  function automatic int div_stages(int ab);
    int frac;
    frac = (ab > TEX_FRAC) ? ab : TEX_FRAC;
    return (STEP_W + frac + DIV_BPS - 1) / DIV_BPS;
  endfunction

  function automatic int latency(int ab);
    return 1 + div_stages(ab) + SINE_LAT + GEOM_LAT;
  endfunction

  function automatic logic [SEG_W-1:0] seg_count(logic [SEG_W-1:0] reg_v);
    logic [SEG_W-1:0] res;
    if (reg_v == '0) begin
      res = SEG_W'(1);
    end else if (32'(reg_v) > 32'(MAX_SEGMENTS - 1)) begin
      res = SEG_W'(MAX_SEGMENTS - 1);
    end else begin
      res = reg_v;
    end
    return res;
  endfunction

endpackage

### rtl/torus_vertex_generator.sv
// Torus vertex generator top: config registers, step clamp, dividers, sines, geometry.
// Depends on tvg_pkg, tvg_delay, tvg_div, tvg_sine, tvg_geom.
//
//  channel   | handshake                     | word
//  ----------+-------------------------------+----------------------------
//  input     | start_i & !busy_o             | in_i     (tvg_pkg::vtx_in_t)
//  result    | result_valid_o, one cycle     | result_o (tvg_pkg::vtx_out_t)
//  config    | cfg_valid_i & cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One word accepted every cycle; busy_o stays low.
// The pipeline is an input register, the pipelined divider at 4 quotient bits
// per stage, the 7-stage polynomial sine and the 3-stage product/saturate
// pipeline.
// Reset clears the config registers to their defaults and all valid bits.
// No stalls: each result is shown for exactly one cycle.
module torus_vertex_generator #(
  parameter int ANGLE_BITS = tvg_pkg::ANGLE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  tvg_pkg::vtx_in_t               in_i,
  output logic                           result_valid_o,
  output tvg_pkg::vtx_out_t              result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tvg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tvg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SEG_W   = tvg_pkg::SEG_W;
  localparam int DIV_ST  = tvg_pkg::div_stages(ANGLE_BITS);
  localparam int NUM_W   = DIV_ST * tvg_pkg::DIV_BPS;
  localparam int TAIL    = tvg_pkg::SINE_LAT + tvg_pkg::GEOM_LAT;
  localparam int IDX_W   = tvg_pkg::IDX_W;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic [tvg_pkg::RAD_W-1:0] major_radius_q, minor_radius_q;
  logic [SEG_W-1:0]          major_segments_q, minor_segments_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_radius_q   <= 16'd256;
      minor_radius_q   <= 16'd64;
      major_segments_q <= 10'd32;
      minor_segments_q <= 10'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tvg_pkg::CFG_MAJOR_RADIUS:   major_radius_q   <= cfg_data_i;
        tvg_pkg::CFG_MINOR_RADIUS:   minor_radius_q   <= cfg_data_i;
        tvg_pkg::CFG_MAJOR_SEGMENTS: major_segments_q <= cfg_data_i[SEG_W-1:0];
        tvg_pkg::CFG_MINOR_SEGMENTS: minor_segments_q <= cfg_data_i[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  logic [SEG_W-1:0] ms, ns, i_d, j_d, i_q, j_q;
  logic             vld_q;

  always_comb begin
    ms  = tvg_pkg::seg_count(major_segments_q);
    ns  = tvg_pkg::seg_count(minor_segments_q);
    i_d = (in_i.major_step > ms) ? ms : in_i.major_step;
    j_d = (in_i.minor_step > ns) ? ns : in_i.minor_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
  end

  logic [NUM_W-1:0] num_th, num_ph, num_u, num_v;
  logic [NUM_W-1:0] quo_th, quo_ph, quo_u, quo_v;

  always_comb begin
    num_th = (NUM_W'(i_q) << ANGLE_BITS) + NUM_W'(ms >> 1);
    num_ph = (NUM_W'(j_q) << ANGLE_BITS) + NUM_W'(ns >> 1);
    num_u  = (NUM_W'(i_q) << tvg_pkg::TEX_FRAC) + NUM_W'(ms >> 1);
    num_v  = (NUM_W'(j_q) << tvg_pkg::TEX_FRAC) + NUM_W'(ns >> 1);
  end

  tvg_div #(.STAGES(DIV_ST)) u_div_th (.clk_i, .num_i(num_th), .den_i(ms), .quo_o(quo_th));
  tvg_div #(.STAGES(DIV_ST)) u_div_ph (.clk_i, .num_i(num_ph), .den_i(ns), .quo_o(quo_ph));
  tvg_div #(.STAGES(DIV_ST)) u_div_u  (.clk_i, .num_i(num_u),  .den_i(ms), .quo_o(quo_u));
  tvg_div #(.STAGES(DIV_ST)) u_div_v  (.clk_i, .num_i(num_v),  .den_i(ns), .quo_o(quo_v));

  logic [ANGLE_BITS-1:0] ph_th, ph_ph;
  logic signed [15:0]    sin_th, cos_th, sin_ph, cos_ph;

  assign ph_th = quo_th[ANGLE_BITS-1:0];
  assign ph_ph = quo_ph[ANGLE_BITS-1:0];

  tvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_th (
    .clk_i, .phase_i(ph_th), .sin_o(sin_th));
  tvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_th (
    .clk_i, .phase_i(ph_th + QUARTER), .sin_o(cos_th));
  tvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_ph (
    .clk_i, .phase_i(ph_ph), .sin_o(sin_ph));
  tvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_ph (
    .clk_i, .phase_i(ph_ph + QUARTER), .sin_o(cos_ph));

  tvg_geom u_geom (
    .clk_i,
    .major_radius_i (major_radius_q),
    .minor_radius_i (minor_radius_q),
    .sin_th_i       (sin_th),
    .cos_th_i       (cos_th),
    .sin_ph_i       (sin_ph),
    .cos_ph_i       (cos_ph),
    .pos_x_o        (result_o.pos_x),
    .pos_y_o        (result_o.pos_y),
    .pos_z_o        (result_o.pos_z),
    .norm_x_o       (result_o.norm_x),
    .norm_y_o       (result_o.norm_y),
    .norm_z_o       (result_o.norm_z),
    .tan_x_o        (result_o.tan_x),
    .tan_z_o        (result_o.tan_z)
  );

  logic [IDX_W-1:0] idx_q;
  logic [20:0]      idx_full;

  assign idx_full = 21'(i_q) * 21'({1'b0, ns} + 11'd1) + 21'(j_q);

  always_ff @(posedge clk_i) begin
    idx_q <= idx_full[IDX_W-1:0];
  end

  tvg_delay #(.W(IDX_W), .DEPTH(DIV_ST + TAIL - 1)) u_dly_idx (
    .clk_i, .rst_ni, .d_i(idx_q), .q_o(result_o.vertex_index));
  tvg_delay #(.W(17), .DEPTH(TAIL)) u_dly_u (
    .clk_i, .rst_ni, .d_i(quo_u[16:0]), .q_o(result_o.tex_u));
  tvg_delay #(.W(17), .DEPTH(TAIL)) u_dly_v (
    .clk_i, .rst_ni, .d_i(quo_v[16:0]), .q_o(result_o.tex_v));
  tvg_delay #(.W(1), .DEPTH(DIV_ST + TAIL)) u_dly_vld (
    .clk_i, .rst_ni, .d_i(vld_q), .q_o(result_valid_o));

endmodule

### rtl/tvg_delay.sv
// Fixed-depth register delay line with cleared reset.
// Depends on nothing.
module tvg_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) sr_q[k] <= '0;
    end else begin
      sr_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) sr_q[k] <= sr_q[k-1];
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

### rtl/tvg_div.sv
// Pipelined restoring divider, DIV_BPS quotient bits per stage.
// Depends on tvg_pkg.
module tvg_div #(
  parameter int STAGES = 7
) (
  input  logic                                      clk_i,
  input  logic [STAGES*tvg_pkg::DIV_BPS-1:0]        num_i,
  input  logic [tvg_pkg::SEG_W-1:0]                 den_i,
  output logic [STAGES*tvg_pkg::DIV_BPS-1:0]        quo_o
);

  localparam int BPS   = tvg_pkg::DIV_BPS;
  localparam int NUM_W = STAGES * BPS;
  localparam int DEN_W = tvg_pkg::SEG_W;

  logic [DEN_W-1:0] rem_q [STAGES];
  logic [NUM_W-1:0] quo_q [STAGES];
  logic [NUM_W-1:0] num_q [STAGES-1];

  for (genvar s = 0; s < STAGES; s++) begin : g_st
    logic [DEN_W-1:0] rem_in, rem_d;
    logic [NUM_W-1:0] num_in, num_d, quo_in, quo_d;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic [DEN_W:0] trial;
      rem_d = rem_in;
      num_d = num_in;
      quo_d = quo_in;
      trial = '0;
      for (int b = 0; b < BPS; b++) begin
        trial = {rem_d, num_d[NUM_W-1]};
        num_d = {num_d[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, den_i}) begin
          rem_d = DEN_W'(trial - {1'b0, den_i});
          quo_d = {quo_d[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = trial[DEN_W-1:0];
          quo_d = {quo_d[NUM_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      quo_q[s] <= quo_d;
    end

    if (s < STAGES - 1) begin : g_num
      always_ff @(posedge clk_i) begin
        num_q[s] <= num_d;
      end
    end
  end

  assign quo_o = quo_q[STAGES-1];

endmodule

### rtl/tvg_sine.sv
// Pipelined sine: quarter-wave fold, degree-9 odd polynomial in Q30, Q1.15 out.
// Depends on tvg_pkg (SINE_LAT stages).
module tvg_sine #(
  parameter int ANGLE_BITS = tvg_pkg::ANGLE_BITS
) (
  input  logic                  clk_i,
  input  logic [ANGLE_BITS-1:0] phase_i,
  output logic signed [15:0]    sin_o
);

  localparam logic [31:0] C1 = 32'd1686629714;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569306;
  localparam logic [31:0] C7 = 32'd5026996;
  localparam logic [31:0] C9 = 32'd172271;
  localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);

  function automatic logic [31:0] mul_q30(logic [30:0] a, logic [31:0] b);
    logic [62:0] p;
    p = 63'(a) * 63'(b);
    return p[61:30];
  endfunction

  logic [30:0] t_a_q, t_b_q, t_c_q, t_d_q, t_e_q, t_f_q;
  logic [1:0]  q_a_q, q_b_q, q_c_q, q_d_q, q_e_q, q_f_q;
  logic [30:0] s_b_q, s_c_q, s_d_q, s_e_q;
  logic [31:0] p_c_q, p_d_q, p_e_q, p_f_q;
  logic signed [15:0] sin_q;

  logic [ANGLE_BITS-2:0] fold;
  logic [31:0] s_full, m_prod;
  logic [32:0] m_rnd;
  logic [14:0] mag;

  always_comb begin
    fold = phase_i[ANGLE_BITS-2] ? QUARTER - {1'b0, phase_i[ANGLE_BITS-3:0]}
                                 : {1'b0, phase_i[ANGLE_BITS-3:0]};
    s_full = mul_q30(t_a_q, {1'b0, t_a_q});
    m_prod = mul_q30(t_f_q, p_f_q);
    m_rnd  = (33'(m_prod) + 33'd16384) >> 15;
    mag    = (m_rnd > 33'd32767) ? 15'h7FFF : m_rnd[14:0];
  end

  always_ff @(posedge clk_i) begin
    t_a_q <= 31'(fold) << (32 - ANGLE_BITS);
    q_a_q <= phase_i[ANGLE_BITS-1:ANGLE_BITS-2];

    t_b_q <= t_a_q;  q_b_q <= q_a_q;  s_b_q <= s_full[30:0];

    t_c_q <= t_b_q;  q_c_q <= q_b_q;  s_c_q <= s_b_q;
    p_c_q <= C7 - mul_q30(s_b_q, C9);

    t_d_q <= t_c_q;  q_d_q <= q_c_q;  s_d_q <= s_c_q;
    p_d_q <= C5 - mul_q30(s_c_q, p_c_q);

    t_e_q <= t_d_q;  q_e_q <= q_d_q;  s_e_q <= s_d_q;
    p_e_q <= C3 - mul_q30(s_d_q, p_d_q);

    t_f_q <= t_e_q;  q_f_q <= q_e_q;
    p_f_q <= C1 - mul_q30(s_e_q, p_e_q);

    sin_q <= q_f_q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign sin_o = sin_q;

endmodule

### rtl/tvg_geom.sv
// Position, normal and tangent products with rounding and saturation.
// Depends on tvg_pkg (GEOM_LAT stages).
module tvg_geom (
  input  logic                       clk_i,
  input  logic [tvg_pkg::RAD_W-1:0]  major_radius_i,
  input  logic [tvg_pkg::RAD_W-1:0]  minor_radius_i,
  input  logic signed [15:0]         sin_th_i,
  input  logic signed [15:0]         cos_th_i,
  input  logic signed [15:0]         sin_ph_i,
  input  logic signed [15:0]         cos_ph_i,
  output logic signed [23:0]         pos_x_o,
  output logic signed [23:0]         pos_y_o,
  output logic signed [23:0]         pos_z_o,
  output logic signed [15:0]         norm_x_o,
  output logic signed [15:0]         norm_y_o,
  output logic signed [15:0]         norm_z_o,
  output logic signed [15:0]         tan_x_o,
  output logic signed [15:0]         tan_z_o
);

  function automatic logic signed [23:0] sat24(logic signed [50:0] v);
    logic signed [23:0] res;
    if (v > 51'sd8388607) res = 24'sh7FFFFF;
    else if (v < -51'sd8388608) res = 24'sh800000;
    else res = v[23:0];
    return res;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [50:0] v);
    logic signed [15:0] res;
    if (v > 51'sd32767) res = 16'sh7FFF;
    else if (v < -51'sd32768) res = 16'sh8000;
    else res = v[15:0];
    return res;
  endfunction

  logic signed [32:0] rc;
  logic signed [33:0] w_1_q;
  logic signed [32:0] py_1_q, py_2_q;
  logic signed [31:0] nx_1_q, nz_1_q, nx_2_q, nz_2_q;
  logic signed [15:0] sth_1_q, cth_1_q, sph_1_q, cth_2_q, sph_2_q, sth_2_q;
  logic signed [49:0] px_2_q, pz_2_q;
  logic signed [50:0] px_s, pz_s, py_s, nx_s, nz_s;

  logic signed [23:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [15:0] norm_x_q, norm_y_q, norm_z_q, tan_x_q, tan_z_q;

  always_comb begin
    rc   = $signed({1'b0, minor_radius_i}) * cos_ph_i;
    px_s = (51'(px_2_q) + (51'sd1 <<< 23)) >>> 24;
    pz_s = (51'(pz_2_q) + (51'sd1 <<< 23)) >>> 24;
    py_s = (51'(py_2_q) + 51'sd256) >>> 9;
    nx_s = (51'(nx_2_q) + 51'sd16384) >>> 15;
    nz_s = (51'(nz_2_q) + 51'sd16384) >>> 15;
  end

  always_ff @(posedge clk_i) begin
    w_1_q   <= $signed({3'b0, major_radius_i, 15'b0}) + 34'(rc);
    py_1_q  <= $signed({1'b0, minor_radius_i}) * sin_ph_i;
    nx_1_q  <= cos_ph_i * cos_th_i;
    nz_1_q  <= cos_ph_i * sin_th_i;
    sth_1_q <= sin_th_i;
    cth_1_q <= cos_th_i;
    sph_1_q <= sin_ph_i;

    px_2_q  <= w_1_q * cth_1_q;
    pz_2_q  <= w_1_q * sth_1_q;
    py_2_q  <= py_1_q;
    nx_2_q  <= nx_1_q;
    nz_2_q  <= nz_1_q;
    sth_2_q <= sth_1_q;
    cth_2_q <= cth_1_q;
    sph_2_q <= sph_1_q;

    pos_x_q  <= sat24(px_s);
    pos_y_q  <= sat24(py_s);
    pos_z_q  <= sat24(pz_s);
    norm_x_q <= sat16(nx_s);
    norm_y_q <= sph_2_q;
    norm_z_q <= sat16(nz_s);
    tan_x_q  <= -sth_2_q;
    tan_z_q  <= cth_2_q;
  end

  assign pos_x_o  = pos_x_q;
  assign pos_y_o  = pos_y_q;
  assign pos_z_o  = pos_z_q;
  assign norm_x_o = norm_x_q;
  assign norm_y_o = norm_y_q;
  assign norm_z_o = norm_z_q;
  assign tan_x_o  = tan_x_q;
  assign tan_z_o  = tan_z_q;

endmodule

### rtl/tvg_checker.sv
// Port-level checks for the torus vertex generator, bound to the top level.
// Depends on tvg_pkg and torus_vertex_generator.
module tvg_checker #(
  parameter int ANGLE_BITS = tvg_pkg::ANGLE_BITS
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              result_valid_o,
  input tvg_pkg::vtx_out_t result_o
);

  localparam int LAT = tvg_pkg::latency(ANGLE_BITS);

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT result_valid_o)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without accepted word");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.tex_u <= 17'd65536) && (result_o.tex_v <= 17'd65536))
    else $error("texture coordinate above one");

  a_sine_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.norm_y != 16'sh8000) && (result_o.tan_z != 16'sh8000))
    else $error("sine out of range");

endmodule

bind torus_vertex_generator tvg_checker #(.ANGLE_BITS(ANGLE_BITS)) u_tvg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

### tb/sv/tb.sv
// Testbench for torus_vertex_generator: directed and random grid points checked
// against an in-bench fixed-point predictor. Depends on tvg_pkg and the block RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT = tvg_pkg::latency(tvg_pkg::ANGLE_BITS);
  localparam int AB = tvg_pkg::ANGLE_BITS;
  localparam longint LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  tvg_pkg::vtx_in_t in_i = '0;
  logic result_valid_o;
  tvg_pkg::vtx_out_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [tvg_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [tvg_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  torus_vertex_generator uut (.*);

  always #1 clk_i = ~clk_i;

  logic [15:0] ring_r, tube_r;
  logic [9:0] ring_seg, tube_seg;
  tvg_pkg::vtx_out_t vertex_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int idle_pct = 28;
  longint cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint eff_seg(logic [9:0] v);
    if (v == 0) return 1;
    if (v > tvg_pkg::MAX_SEGMENTS - 1) return tvg_pkg::MAX_SEGMENTS - 1;
    return longint'(v);
  endfunction

  function automatic longint quarter_sin(longint t);
    longint s, p;
    s = (t * t) >>> 30;
    p = 172271;
    p = 5026996 - ((s * p) >>> 30);
    p = 85569306 - ((s * p) >>> 30);
    p = 693598668 - ((s * p) >>> 30);
    p = 1686629714 - ((s * p) >>> 30);
    return (t * p) >>> 30;
  endfunction

  function automatic longint sin15(longint phase);
    longint qtr, q, rr, m;
    qtr = 64'd1 << (AB - 2);
    q = (phase >> (AB - 2)) & 3;
    rr = phase & (qtr - 1);
    if (q & 1) rr = qtr - rr;
    m = (quarter_sin(rr << (32 - AB)) + (64'd1 << 14)) >>> 15;
    if (m > 32767) m = 32767;
    return (q & 2) ? -m : m;
  endfunction

  function automatic longint rshift(longint v, int n);
    v += 64'sd1 <<< (n - 1);
    return v >>> n;
  endfunction

  function automatic longint sat(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic tvg_pkg::vtx_out_t vertex_of(tvg_pkg::vtx_in_t x);
    tvg_pkg::vtx_out_t o;
    longint ms, ns, i, j, pth, pph, sth, cth, sph, cph, w, qtr, mask;
    ms = eff_seg(ring_seg);
    ns = eff_seg(tube_seg);
    i = x.major_step;
    j = x.minor_step;
    if (i > ms) i = ms;
    if (j > ns) j = ns;
    qtr = 64'd1 << (AB - 2);
    mask = (64'd1 << AB) - 1;
    pth = (((i << AB) + (ms >> 1)) / ms) & mask;
    pph = (((j << AB) + (ns >> 1)) / ns) & mask;
    sth = sin15(pth);
    cth = sin15((pth + qtr) & mask);
    sph = sin15(pph);
    cph = sin15((pph + qtr) & mask);
    w = longint'(ring_r) * 32768 + longint'(tube_r) * cph;
    o.pos_x = 24'(sat(rshift(w * cth, 24), 24));
    o.pos_y = 24'(sat(rshift(longint'(tube_r) * sph, 9), 24));
    o.pos_z = 24'(sat(rshift(w * sth, 24), 24));
    o.norm_x = 16'(sat(rshift(cph * cth, 15), 16));
    o.norm_y = 16'(sph);
    o.norm_z = 16'(sat(rshift(cph * sth, 15), 16));
    o.tan_x = 16'(-sth);
    o.tan_z = 16'(cth);
    o.tex_u = 17'(((i << 16) + (ms >> 1)) / ms);
    o.tex_v = 17'(((j << 16) + (ns >> 1)) / ns);
    o.vertex_index = 20'(i * (ns + 1) + j);
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    if (errors <= 40)
      $display("Mismatch %s at vertex %0d: got %0d, expected %0d", what, n_seen, got, want);
  endtask

  always @(posedge clk_i) begin
    tvg_pkg::vtx_out_t e;
    if (rst_ni && result_valid_o) begin
      if (vertex_q.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        e = vertex_q.pop_front();
        if (result_o.pos_x !== e.pos_x) report("pos_x", result_o.pos_x, e.pos_x);
        if (result_o.pos_y !== e.pos_y) report("pos_y", result_o.pos_y, e.pos_y);
        if (result_o.pos_z !== e.pos_z) report("pos_z", result_o.pos_z, e.pos_z);
        if (result_o.norm_x !== e.norm_x) report("norm_x", result_o.norm_x, e.norm_x);
        if (result_o.norm_y !== e.norm_y) report("norm_y", result_o.norm_y, e.norm_y);
        if (result_o.norm_z !== e.norm_z) report("norm_z", result_o.norm_z, e.norm_z);
        if (result_o.tan_x !== e.tan_x) report("tan_x", result_o.tan_x, e.tan_x);
        if (result_o.tan_z !== e.tan_z) report("tan_z", result_o.tan_z, e.tan_z);
        if (result_o.tex_u !== e.tex_u) report("tex_u", result_o.tex_u, e.tex_u);
        if (result_o.tex_v !== e.tex_v) report("tex_v", result_o.tex_v, e.tex_v);
        if (result_o.vertex_index !== e.vertex_index)
          report("vertex_index", result_o.vertex_index, e.vertex_index);
      end
      n_seen++;
    end
  end

  // start_i stays high across back-to-back words; lowered only on a gap
  task automatic send_vertex(logic [9:0] i, logic [9:0] j);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= '{major_step: i, minor_step: j};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    vertex_q = {vertex_q, vertex_of('{major_step: i, minor_step: j})};
    n_sent++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(tvg_pkg::cfg_reg_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      tvg_pkg::CFG_MAJOR_RADIUS: ring_r = val;
      tvg_pkg::CFG_MINOR_RADIUS: tube_r = val;
      tvg_pkg::CFG_MAJOR_SEGMENTS: ring_seg = val[9:0];
      tvg_pkg::CFG_MINOR_SEGMENTS: tube_seg = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(logic [15:0] rr, logic [15:0] tr, logic [15:0] ms, logic [15:0] ns);
    write_reg(tvg_pkg::CFG_MAJOR_RADIUS, rr);
    write_reg(tvg_pkg::CFG_MINOR_RADIUS, tr);
    write_reg(tvg_pkg::CFG_MAJOR_SEGMENTS, ms);
    write_reg(tvg_pkg::CFG_MINOR_SEGMENTS, ns);
  endtask

  task automatic test_directed();
    send_vertex(10'd0, 10'd0);
    send_vertex(10'd8, 10'd4);
    send_vertex(10'd32, 10'd16);
    send_vertex(10'd1023, 10'd1023);
    send_vertex(10'd33, 10'd0);
    send_vertex(10'h155, 10'h2AA);
    send_vertex(10'h2AA, 10'h155);
    drain();
    set_shape(16'h0100, 16'h0000, 16'd0, 16'd0);
    send_vertex(10'd0, 10'd0);
    send_vertex(10'd1, 10'd1);
    send_vertex(10'd5, 10'd7);
    drain();
    set_shape(16'h0010, 16'h0400, 16'hFFFF, 16'd1023);
    send_vertex(10'd0, 10'd1023);
    send_vertex(10'd256, 10'd512);
    send_vertex(10'd511, 10'd767);
    drain();
    set_shape(16'hFFFF, 16'hFFFF, 16'd4, 16'd4);
    for (int k = 0; k < 5; k++) send_vertex(10'(k), 10'(4 - k));
    drain();
  endtask

  task automatic test_random_shapes();
    logic [15:0] rr, tr;
    logic [9:0] ms, ns;
    for (int ph = 0; ph < 12; ph++) begin
      rr = 16'($urandom);
      tr = 16'($urandom);
      ms = (ph % 3 == 0) ? 10'($urandom) : 10'($urandom_range(1, 40));
      ns = (ph % 3 == 1) ? 10'($urandom) : 10'($urandom_range(1, 40));
      set_shape(rr, tr, {6'd0, ms}, {6'd0, ns});
      idle_pct = (ph == 5) ? 0 : 28;
      for (int k = 0; k < 150; k++) begin
        if ($urandom_range(9) == 0)
          send_vertex(10'($urandom), 10'($urandom));
        else
          send_vertex(10'($urandom_range(0, 32'(eff_seg(ms)))),
                      10'($urandom_range(0, 32'(eff_seg(ns)))));
      end
      drain();
      repeat (LAT) @(posedge clk_i);
    end
    idle_pct = 28;
  endtask

  initial begin
    ring_r = 16'd256;
    tube_r = 16'd64;
    ring_seg = 10'd32;
    tube_seg = 10'd16;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_shapes();
    repeat (LAT + 4) @(posedge clk_i);
    $display("Sent %0d grid points over 16 torus shapes, %0d vertices checked",
             n_sent, n_seen);
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Errors %0d, still pending %0d", errors, vertex_q.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### files.f
rtl/tvg_pkg.sv
rtl/tvg_delay.sv
rtl/tvg_div.sv
rtl/tvg_sine.sv
rtl/tvg_geom.sv
rtl/torus_vertex_generator.sv
rtl/tvg_checker.sv
tb/sv/tb.sv
